// ===== rtl/dab_tdi_pkg.sv =====
// Shared types, constants and the branch delay map of the DAB time deinterleaver.
package dab_tdi_pkg;

  localparam int unsigned SOFT_W          = 8;
  localparam int unsigned FRAG_W          = 14;
  localparam int unsigned SLOT_W          = 4;
  localparam int unsigned BRANCHES        = 16;
  localparam int unsigned PRIME_W         = 5;
  localparam int unsigned MAX_FRAGMENT_DEF = 8192;

  localparam logic [FRAG_W-1:0]  FRAGMENT_RESET  = FRAG_W'(64);
  localparam logic [PRIME_W-1:0] FRAMES_TO_PRIME = PRIME_W'(BRANCHES);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [SOFT_W-1:0]  soft_t;

  // Per-request flags carried from address generation to the output stage
  typedef struct packed {
    logic accept;
    logic emit;
    logic last;
  } tdi_req_t;

  // Branch offset for column i mod 16 (bit-reversed slot order)
  function automatic slot_t branch_map(input logic [SLOT_W-1:0] col_lsb);
    slot_t m;
    case (col_lsb)
      4'd0:    m = 4'd0;
      4'd1:    m = 4'd8;
      4'd2:    m = 4'd4;
      4'd3:    m = 4'd12;
      4'd4:    m = 4'd2;
      4'd5:    m = 4'd10;
      4'd6:    m = 4'd6;
      4'd7:    m = 4'd14;
      4'd8:    m = 4'd1;
      4'd9:    m = 4'd9;
      4'd10:   m = 4'd5;
      4'd11:   m = 4'd13;
      4'd12:   m = 4'd3;
      4'd13:   m = 4'd11;
      4'd14:   m = 4'd7;
      4'd15:   m = 4'd15;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/dab_tdi_mem.sv =====
// Branch store: simple dual-port synchronous RAM, read-first, registered read.
module dab_tdi_mem
  import dab_tdi_pkg::*;
#(
  parameter int unsigned ADDR_W = 17
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output soft_t             rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  soft_t             wr_data
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  soft_t mem [DEPTH];

  // read returns the old value when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== rtl/dab_tdi_ctrl.sv =====
// Frame counters, address generation, config register and output handshake.
module dab_tdi_ctrl
  import dab_tdi_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENT = MAX_FRAGMENT_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [FRAG_W-1:0]                           cfg_wdata,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic                                        out_ready,
  output logic                                        out_valid,
  output logic                                        last_in_frame,
  output tdi_req_t                                    req,
  output logic [SLOT_W+$clog2(MAX_FRAGMENT)-1:0]      rd_addr,
  output logic [SLOT_W+$clog2(MAX_FRAGMENT)-1:0]      wr_addr
);

  localparam int unsigned COL_W = $clog2(MAX_FRAGMENT);
  localparam int unsigned LEN_W = $clog2(MAX_FRAGMENT + 1);
  localparam int unsigned CMP_W = (LEN_W > FRAG_W) ? LEN_W : FRAG_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAGMENT);

  logic [FRAG_W-1:0]  fragment_size;
  logic [COL_W-1:0]   bit_position;
  slot_t              branch_index;
  logic [PRIME_W-1:0] frames_primed;

  logic [CMP_W-1:0]   frag_ext;
  logic [CMP_W-1:0]   frame_len;
  logic [CMP_W-1:0]   col_plus1;
  slot_t              rd_slot;

  // effective frame length: zero acts as one, clamp to MAX_FRAGMENT
  always_comb begin
    frag_ext = CMP_W'(fragment_size);
    if (frag_ext == '0) begin
      frame_len = CMP_W'(1);
    end else if (frag_ext > MAX_LEN) begin
      frame_len = MAX_LEN;
    end else begin
      frame_len = frag_ext;
    end
  end

  // request flags and addresses
  always_comb begin
    in_ready   = !out_valid || out_ready;
    col_plus1  = CMP_W'(bit_position) + CMP_W'(1);
    req.accept = in_valid && in_ready;
    req.last   = col_plus1 >= frame_len;
    req.emit   = frames_primed >= FRAMES_TO_PRIME;
    rd_slot    = branch_index + branch_map(bit_position[SLOT_W-1:0]);
    rd_addr    = {rd_slot, bit_position};
    wr_addr    = {branch_index, bit_position};
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_size <= FRAGMENT_RESET;
    end else if (cfg_we) begin
      fragment_size <= cfg_wdata;
    end
  end

  // frame position, branch and priming counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      branch_index  <= '0;
      frames_primed <= '0;
    end else if (req.accept) begin
      if (req.last) begin
        bit_position <= '0;
        branch_index <= branch_index + slot_t'(1);
        if (!req.emit) begin
          frames_primed <= frames_primed + PRIME_W'(1);
        end
      end else begin
        bit_position <= bit_position + COL_W'(1);
      end
    end
  end

  // output slot; data comes from the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.accept) begin
      out_valid <= req.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.accept) begin
      last_in_frame <= req.last;
    end
  end

endmodule

// ===== rtl/dab_time_deinterleaver.sv =====
// DAB sixteen-branch time deinterleaver top level.
// Output follows the input request in the next cycle (registered RAM read).
// Throughput: 1 soft bit per cycle unless out_ready stalls; one RAM read and
// write per request. No output in the first 16 frames after reset (priming).
// Reset: synchronous; clears counters, output valid and sets frame size to 64.
// The branch store is not cleared; entries are read only after being written.
module dab_time_deinterleaver
  import dab_tdi_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENT = MAX_FRAGMENT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [FRAG_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] soft_bit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] soft_bit_out,
  output logic              last_in_frame
);

  localparam int unsigned ADDR_W = SLOT_W + $clog2(MAX_FRAGMENT);

  tdi_req_t          req;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  soft_t             rd_data;

  dab_tdi_ctrl #(
    .MAX_FRAGMENT (MAX_FRAGMENT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .last_in_frame (last_in_frame),
    .req           (req),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr)
  );

  // read old entry and write the new bit in the same cycle
  dab_tdi_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (req.accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (req.accept),
    .wr_addr (wr_addr),
    .wr_data (soft_t'(soft_bit))
  );

  assign soft_bit_out = $signed(rd_data);

endmodule
